@@ rtl/core/rcfr_pkg.sv @@
// Shared types, constants and helpers for the receiver channel decoder.
// Used by rcfr_div6 and rc_frame_receiver_channel_decode; no dependencies.
`default_nettype none

package rcfr_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'h55;
    localparam logic [7:0] HDR_SECOND = 8'hAA;
    localparam logic [7:0] TRL_FIRST  = 8'hAA;
    localparam logic [7:0] TRL_SECOND = 8'h55;

    localparam int USED_BYTES = 18;
    localparam int IDX_W      = $clog2(USED_BYTES);
    localparam int N_WORDS    = USED_BYTES / 2;

    localparam logic [15:0] THROTTLE_BASE = 16'd340;

    // floor(x / 6) == (x * DIV6_MULT) >> DIV6_SHIFT for every x below 2**17
    localparam logic [15:0] DIV6_MULT  = 16'd43691;
    localparam int          DIV6_SHIFT = 18;
    localparam int          QUOT_W     = 32 - DIV6_SHIFT;

    localparam logic [15:0] RST_PULSE_MIN = 16'd568;
    localparam logic [15:0] RST_PULSE_MID = 16'd1024;
    localparam logic [15:0] RST_PULSE_MAX = 16'd1478;

    localparam logic [1:0] CFG_PULSE_MIN = 2'd0;
    localparam logic [1:0] CFG_PULSE_MID = 2'd1;
    localparam logic [1:0] CFG_PULSE_MAX = 2'd2;

    localparam logic [1:0] CTRL_MIN = 2'd0;
    localparam logic [1:0] CTRL_MID = 2'd1;
    localparam logic [1:0] CTRL_MAX = 2'd2;
    localparam logic [1:0] CTRL_ERR = 2'd3;

    localparam logic [1:0] GAIT_TROT  = 2'd0;
    localparam logic [1:0] GAIT_WALK  = 2'd1;
    localparam logic [1:0] GAIT_STAND = 2'd2;
    localparam logic [1:0] GAIT_ERR   = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HDR     = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_TRL1    = 3'd3,
        PH_TRL2    = 3'd4
    } phase_t;

    typedef struct packed {
        logic        neg;
        logic [15:0] mag;
    } diff_t;

    function automatic diff_t pulse_diff(input logic [15:0] pulse, input logic [15:0] base);
        diff_t d;
        if (pulse >= base) begin
            d.neg = 1'b0;
            d.mag = pulse - base;
        end else begin
            d.neg = 1'b1;
            d.mag = base - pulse;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/rc_frame_receiver_channel_decode.sv @@
// Receiver channel decoder: framed byte parser and two-stage channel scaling.
// Result is registered in stage 1 when the trailer byte is accepted, then in the stage 2 result register.
// Throughput: one byte per cycle while s_ready is high; one result per good frame.
// Reset (aresetn low, synchronous): parser hunts for the header, pipeline
// empties, pulse registers return to 568 / 1024 / 1478. Payload store is not reset.
// Depends on rcfr_pkg and rcfr_div6.
`default_nettype none

module rc_frame_receiver_channel_decode
    import rcfr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 18
) (
    input  wire              aclk,
    input  wire              aresetn,

    input  wire              cfg_wr_en,
    input  wire  [1:0]       cfg_index,
    input  wire  [15:0]      cfg_wdata,

    input  wire              s_valid,
    output logic             s_ready,
    input  wire  [7:0]       s_rx_byte,

    output logic             m_valid,
    input  wire              m_ready,
    output logic signed [7:0] m_left_x,
    output logic signed [7:0] m_left_y,
    output logic signed [7:0] m_right_x,
    output logic signed [7:0] m_right_y,
    output logic [1:0]       m_control_mode,
    output logic [1:0]       m_gait_mode,
    output logic [7:0]       m_throttle
);

    localparam int CNT_W = $clog2(PAYLOAD_BYTES);

    logic [15:0] pulse_min_reg, pulse_mid_reg, pulse_max_reg;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]         store_reg [USED_BYTES];

    logic        accept;
    logic        store_we;
    logic        frame_ok;
    logic        cnt_last;
    logic [15:0] words [N_WORDS];

    // stage 1: sign/magnitude and mode codes
    logic        s1_valid_reg, s1_valid_next;
    diff_t       s1_lx_reg, s1_ly_reg, s1_rx_reg, s1_ry_reg, s1_thr_reg;
    logic [1:0]  s1_ctrl_reg, s1_gait_reg;
    logic [1:0]  ctrl_code, gait_code;

    // stage 2: result register
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  lx_q, ly_q, rx_q, ry_q, thr_q;
    logic [7:0]  lx_reg, ly_reg, rx_reg, ry_reg, thr_reg;
    logic [1:0]  ctrl_reg, gait_reg;

    logic        adv_out;

    assign adv_out = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || adv_out;
    assign accept  = s_valid && s_ready;
    assign cnt_last = (cnt_reg == CNT_W'(PAYLOAD_BYTES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_min_reg <= RST_PULSE_MIN;
            pulse_mid_reg <= RST_PULSE_MID;
            pulse_max_reg <= RST_PULSE_MAX;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PULSE_MIN: pulse_min_reg <= cfg_wdata;
                CFG_PULSE_MID: pulse_mid_reg <= cfg_wdata;
                CFG_PULSE_MAX: pulse_max_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    phase_next = (s_rx_byte == HDR_FIRST) ? PH_HDR : PH_HUNT;
                end
                PH_HDR: begin
                    if (s_rx_byte == HDR_SECOND) begin
                        phase_next = PH_PAYLOAD;
                        cnt_next   = '0;
                    end else if (s_rx_byte != HDR_FIRST) begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_PAYLOAD: begin
                    if (cnt_last) begin
                        phase_next = PH_TRL1;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                PH_TRL1: begin
                    phase_next = (s_rx_byte == TRL_FIRST) ? PH_TRL2 : PH_HUNT;
                end
                PH_TRL2: begin
                    phase_next = PH_HUNT;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        store_we = 1'b0;
        frame_ok = 1'b0;
        unique case (phase_reg)
            PH_PAYLOAD: store_we = accept && (cnt_reg < CNT_W'(USED_BYTES));
            PH_TRL2:    frame_ok = accept && (s_rx_byte == TRL_SECOND);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[cnt_reg[IDX_W-1:0]] <= s_rx_byte;
        end
    end

    always_comb begin
        for (int k = 0; k < N_WORDS; k++) begin
            words[k] = {store_reg[2*k+1], store_reg[2*k]};
        end
    end

    always_comb begin
        if (words[7] == pulse_min_reg) begin
            ctrl_code = CTRL_MIN;
        end else if (words[7] == pulse_mid_reg) begin
            ctrl_code = CTRL_MID;
        end else if (words[7] == pulse_max_reg) begin
            ctrl_code = CTRL_MAX;
        end else begin
            ctrl_code = CTRL_ERR;
        end

        if (words[8] == pulse_min_reg) begin
            gait_code = GAIT_TROT;
        end else if (words[8] == pulse_max_reg) begin
            gait_code = GAIT_WALK;
        end else if (words[8] == pulse_mid_reg) begin
            gait_code = GAIT_STAND;
        end else begin
            gait_code = GAIT_ERR;
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (frame_ok) begin
            s1_valid_next = 1'b1;
        end else if (s1_valid_reg && adv_out) begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (s1_valid_reg && adv_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_ok) begin
            s1_lx_reg   <= pulse_diff(words[3], pulse_mid_reg);
            s1_ly_reg   <= pulse_diff(words[1], pulse_mid_reg);
            s1_rx_reg   <= pulse_diff(words[0], pulse_mid_reg);
            s1_ry_reg   <= pulse_diff(words[2], pulse_mid_reg);
            s1_thr_reg  <= pulse_diff(words[4], THROTTLE_BASE);
            s1_ctrl_reg <= ctrl_code;
            s1_gait_reg <= gait_code;
        end
    end

    rcfr_div6 u_div_lx  (.diff(s1_lx_reg),  .quot(lx_q));
    rcfr_div6 u_div_ly  (.diff(s1_ly_reg),  .quot(ly_q));
    rcfr_div6 u_div_rx  (.diff(s1_rx_reg),  .quot(rx_q));
    rcfr_div6 u_div_ry  (.diff(s1_ry_reg),  .quot(ry_q));
    rcfr_div6 u_div_thr (.diff(s1_thr_reg), .quot(thr_q));

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && adv_out) begin
            lx_reg   <= lx_q;
            ly_reg   <= ly_q;
            rx_reg   <= rx_q;
            ry_reg   <= ry_q;
            thr_reg  <= thr_q;
            ctrl_reg <= s1_ctrl_reg;
            gait_reg <= s1_gait_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_left_x       = lx_reg;
    assign m_left_y       = ly_reg;
    assign m_right_x      = rx_reg;
    assign m_right_y      = ry_reg;
    assign m_control_mode = ctrl_reg;
    assign m_gait_mode    = gait_reg;
    assign m_throttle     = thr_reg;

endmodule

`default_nettype wire

@@ rtl/core/rcfr_div6.sv @@
// Signed divide by six with truncation toward zero, wrapped to 8 bits.
// Takes a sign and magnitude pair; depends on rcfr_pkg.
`default_nettype none

module rcfr_div6
    import rcfr_pkg::*;
(
    input  var diff_t       diff,
    output logic [7:0]      quot
);

    logic [31:0]       prod;
    logic [QUOT_W-1:0] q;
    logic [7:0]        q8;

    assign prod = 32'(diff.mag) * 32'(DIV6_MULT);
    assign q    = prod[31:DIV6_SHIFT];
    assign q8   = q[7:0];
    assign quot = diff.neg ? (~q8 + 8'd1) : q8;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Testbench for rc_frame_receiver_channel_decode: framed bytes in, decoded channels out.
// Directed frame table, then random frames and noise, checked against table results or a local decoder.
// Depends on rcfr_pkg and the decoder RTL.

module tb;
    import rcfr_pkg::*;

    localparam int          SCALE_DIV   = 6;
    localparam int          CFG_SETTLE  = 4;
    localparam int          IDLE_LIMIT  = 3000;
    localparam int          RAND_BYTES  = 1140;
    localparam int          N_ROWS      = 14;
    localparam logic [1:0]  CFG_NONE    = 2'd3;

    typedef struct packed {
        logic signed [7:0] lx;
        logic signed [7:0] ly;
        logic signed [7:0] rx;
        logic signed [7:0] ry;
        logic [1:0]        ctl;
        logic [1:0]        gait;
        logic [7:0]        thr;
    } chan_res_t;

    typedef struct {
        bit          cfg;
        logic [15:0] pmin;
        logic [15:0] pmid;
        logic [15:0] pmax;
        int          nhdr;
        logic [15:0] stick;
        logic [15:0] thr;
        logic [15:0] ctl;
        logic [15:0] gait;
        logic [7:0]  t1;
        logic [7:0]  t2;
        bit          typed;
        chan_res_t   res;
    } frame_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [1:0]        cfg_index = '0;
    logic [15:0]       cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [7:0]        s_rx_byte = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic signed [7:0] m_left_x;
    logic signed [7:0] m_left_y;
    logic signed [7:0] m_right_x;
    logic signed [7:0] m_right_y;
    logic [1:0]        m_control_mode;
    logic [1:0]        m_gait_mode;
    logic [7:0]        m_throttle;

    rc_frame_receiver_channel_decode dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_x      (m_left_x),
        .m_left_y      (m_left_y),
        .m_right_x     (m_right_x),
        .m_right_y     (m_right_y),
        .m_control_mode(m_control_mode),
        .m_gait_mode   (m_gait_mode),
        .m_throttle    (m_throttle)
    );

    always #10 aclk = ~aclk;

    // decoder copy
    phase_t      ph = PH_HUNT;
    int          byte_cnt = 0;
    logic [7:0]  payload [USED_BYTES];
    logic [15:0] cur_min = RST_PULSE_MIN;
    logic [15:0] cur_mid = RST_PULSE_MID;
    logic [15:0] cur_max = RST_PULSE_MAX;

    chan_res_t   pending_chans [$];
    frame_row_t  rows [N_ROWS];
    int          mismatch_cnt = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          rand_bytes = 0;
    int          rdy_left = 0;
    bit          rdy_level = 1'b0;

    function automatic logic [7:0] scaled_pulse(input logic [15:0] p, input logic [15:0] base);
        int d;
        d = int'(p) - int'(base);
        return 8'(d / SCALE_DIV);
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, output chan_res_t r);
        logic [15:0] w [N_WORDS];
        r = '0;
        case (ph)
            PH_HUNT: begin
                ph = (b == HDR_FIRST) ? PH_HDR : PH_HUNT;
                return 1'b0;
            end
            PH_HDR: begin
                if (b == HDR_SECOND) begin
                    byte_cnt = 0;
                    ph = PH_PAYLOAD;
                end else if (b != HDR_FIRST) begin
                    ph = PH_HUNT;
                end
                return 1'b0;
            end
            PH_PAYLOAD: begin
                payload[byte_cnt] = b;
                byte_cnt++;
                if (byte_cnt >= USED_BYTES) begin
                    byte_cnt = 0;
                    ph = PH_TRL1;
                end
                return 1'b0;
            end
            PH_TRL1: begin
                ph = (b == TRL_FIRST) ? PH_TRL2 : PH_HUNT;
                return 1'b0;
            end
            PH_TRL2: begin
                ph = PH_HUNT;
                if (b != TRL_SECOND)
                    return 1'b0;
            end
            default: begin
                ph = PH_HUNT;
                return 1'b0;
            end
        endcase
        for (int k = 0; k < N_WORDS; k++)
            w[k] = {payload[2*k+1], payload[2*k]};
        r.lx  = scaled_pulse(w[3], cur_mid);
        r.ly  = scaled_pulse(w[1], cur_mid);
        r.rx  = scaled_pulse(w[0], cur_mid);
        r.ry  = scaled_pulse(w[2], cur_mid);
        r.thr = scaled_pulse(w[4], THROTTLE_BASE);
        if (w[7] == cur_min)      r.ctl = CTRL_MIN;
        else if (w[7] == cur_mid) r.ctl = CTRL_MID;
        else if (w[7] == cur_max) r.ctl = CTRL_MAX;
        else                      r.ctl = CTRL_ERR;
        if (w[8] == cur_min)      r.gait = GAIT_TROT;
        else if (w[8] == cur_max) r.gait = GAIT_WALK;
        else if (w[8] == cur_mid) r.gait = GAIT_STAND;
        else                      r.gait = GAIT_ERR;
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed, input chan_res_t tres);
        chan_res_t r;
        int gap;
        if (decode_byte(b, r))
            pending_chans.push_back(typed ? tres : r);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 4);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic send_frame(input int nhdr, input logic [15:0] w [N_WORDS],
                              input logic [7:0] t1, input logic [7:0] t2,
                              input bit typed, input chan_res_t tres);
        repeat (nhdr) send_byte(HDR_FIRST, 1'b0, '0);
        send_byte(HDR_SECOND, 1'b0, '0);
        for (int k = 0; k < N_WORDS; k++) begin
            send_byte(w[k][7:0], 1'b0, '0);
            send_byte(w[k][15:8], 1'b0, '0);
        end
        send_byte(t1, 1'b0, '0);
        send_byte(t2, typed, tres);
    endtask

    task automatic set_pulses(input logic [15:0] pmin, input logic [15:0] pmid,
                              input logic [15:0] pmax);
        s_valid <= 1'b0;
        while (pending_chans.size() != 0) @(posedge aclk);
        repeat (CFG_SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PULSE_MIN;
        cfg_wdata <= pmin;
        @(posedge aclk);
        cfg_index <= CFG_PULSE_MID;
        cfg_wdata <= pmid;
        @(posedge aclk);
        cfg_index <= CFG_PULSE_MAX;
        cfg_wdata <= pmax;
        @(posedge aclk);
        cfg_index <= CFG_NONE;
        cfg_wdata <= 16'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_min = pmin;
        cur_mid = pmid;
        cur_max = pmax;
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 8))
            0: return cur_min;
            1: return cur_mid;
            2: return cur_max;
            3: return 16'h0000;
            4: return 16'hFFFF;
            5, 6: return cur_mid + 16'($urandom_range(0, 1600)) - 16'd800;
            7: return THROTTLE_BASE + 16'($urandom_range(0, 40)) - 16'd20;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? HDR_FIRST : HDR_SECOND;
        return 8'($urandom);
    endfunction

    // receiver stall pattern
    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            rdy_left  = $urandom_range(1, 12);
            rdy_level = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 15) == 0) begin
                rdy_left  = 150;
                rdy_level = 1'b1;
            end
        end
        rdy_left--;
        m_ready <= rdy_level;
    end

    always @(posedge aclk) begin
        chan_res_t act;
        chan_res_t exp_r;
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (aresetn && m_valid && m_ready) begin
            act = '{m_left_x, m_left_y, m_right_x, m_right_y,
                    m_control_mode, m_gait_mode, m_throttle};
            if (pending_chans.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display({"unexpected chan result: ",
                              "lx=%0d ly=%0d rx=%0d ry=%0d ctl=%0d gait=%0d thr=%0d"},
                             act.lx, act.ly, act.rx, act.ry, act.ctl, act.gait, act.thr);
            end else begin
                exp_r = pending_chans.pop_front();
                if (act.lx !== exp_r.lx || act.ly !== exp_r.ly || act.rx !== exp_r.rx ||
                    act.ry !== exp_r.ry || act.ctl !== exp_r.ctl ||
                    act.gait !== exp_r.gait || act.thr !== exp_r.thr) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display({"chan result differs: exp ",
                                  "lx=%0d ly=%0d rx=%0d ry=%0d ctl=%0d gait=%0d thr=%0d"},
                                 exp_r.lx, exp_r.ly, exp_r.rx, exp_r.ry,
                                 exp_r.ctl, exp_r.gait, exp_r.thr);
                        $display({"                     act ",
                                  "lx=%0d ly=%0d rx=%0d ry=%0d ctl=%0d gait=%0d thr=%0d"},
                                 act.lx, act.ly, act.rx, act.ry, act.ctl, act.gait, act.thr);
                    end
                end
            end
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("rc_frame_receiver_channel_decode: mismatch");
            $finish;
        end
    end

    initial begin
        logic [15:0] w [N_WORDS];
        logic [7:0]  t1;
        logic [7:0]  t2;
        logic [15:0] v;
        int          nframes;
        int          kind;
        int          nhdr;

        rows = '{
            '{0, 0, 0, 0, 1, 16'd1024, 16'd1024, 16'd1024, 16'd1024, TRL_FIRST, TRL_SECOND,
              1, '{8'sd0, 8'sd0, 8'sd0, 8'sd0, CTRL_MID, GAIT_STAND, 8'd114}},
            '{0, 0, 0, 0, 3, 16'd568, 16'd568, 16'd568, 16'd568, TRL_FIRST, TRL_SECOND,
              1, '{-8'sd76, -8'sd76, -8'sd76, -8'sd76, CTRL_MIN, GAIT_TROT, 8'd38}},
            '{0, 0, 0, 0, 2, 16'd1478, 16'd1478, 16'd1478, 16'd1478, TRL_FIRST, TRL_SECOND,
              1, '{8'sd75, 8'sd75, 8'sd75, 8'sd75, CTRL_MAX, GAIT_WALK, 8'd189}},
            '{0, 0, 0, 0, 1, 16'd0, 16'd0, 16'd0, 16'd0, TRL_FIRST, TRL_SECOND,
              1, '{8'sd86, 8'sd86, 8'sd86, 8'sd86, CTRL_ERR, GAIT_ERR, 8'd200}},
            '{0, 0, 0, 0, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, TRL_FIRST, TRL_SECOND,
              0, '0},
            '{0, 0, 0, 0, 1, 16'd1024, 16'd1024, 16'd1024, 16'd1024, TRL_SECOND, TRL_FIRST,
              0, '0},
            '{0, 0, 0, 0, 2, 16'd1000, 16'd300, 16'd568, 16'd1478, TRL_FIRST, TRL_FIRST,
              0, '0},
            '{0, 0, 0, 0, 1, 16'd1018, 16'd339, 16'd1478, 16'd568, TRL_FIRST, TRL_SECOND,
              0, '0},
            '{0, 0, 0, 0, 1, 16'd1030, 16'd100, 16'd1024, 16'd1478, TRL_FIRST, TRL_SECOND,
              0, '0},
            '{1, 16'd700, 16'd700, 16'd700, 1, 16'd700, 16'd700, 16'd700, 16'd700,
              TRL_FIRST, TRL_SECOND,
              1, '{8'sd0, 8'sd0, 8'sd0, 8'sd0, CTRL_MIN, GAIT_TROT, 8'd60}},
            '{1, 16'd0, 16'd2000, 16'd2000, 1, 16'd2000, 16'd2000, 16'd2000, 16'd2000,
              TRL_FIRST, TRL_SECOND,
              1, '{8'sd0, 8'sd0, 8'sd0, 8'sd0, CTRL_MID, GAIT_WALK, 8'd20}},
            '{1, 16'd0, 16'hFFFF, 16'h8000, 2, 16'd0, 16'hFFFF, 16'hFFFF, 16'h8000,
              TRL_FIRST, TRL_SECOND, 0, '0},
            '{1, 16'hFFFF, 16'd0, 16'd1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1,
              TRL_FIRST, TRL_SECOND, 0, '0},
            '{1, RST_PULSE_MIN, RST_PULSE_MID, RST_PULSE_MAX, 1, 16'd1024, 16'd340,
              16'd568, 16'd1024, TRL_FIRST, TRL_SECOND, 0, '0}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_ROWS; i++) begin
            if (rows[i].cfg)
                set_pulses(rows[i].pmin, rows[i].pmid, rows[i].pmax);
            for (int k = 0; k < 4; k++)
                w[k] = rows[i].stick;
            w[4] = rows[i].thr;
            w[5] = 16'hAA55;
            w[6] = 16'h55AA;
            w[7] = rows[i].ctl;
            w[8] = rows[i].gait;
            send_frame(rows[i].nhdr, w, rows[i].t1, rows[i].t2, rows[i].typed, rows[i].res);
        end

        nframes = 0;
        while (rand_bytes < RAND_BYTES) begin
            if (nframes % 12 == 0) begin
                case ($urandom_range(0, 4))
                    0: set_pulses(RST_PULSE_MIN, RST_PULSE_MID, RST_PULSE_MAX);
                    1: set_pulses(16'($urandom), 16'($urandom), 16'($urandom));
                    2: begin
                        v = 16'($urandom);
                        set_pulses(v, v, v);
                    end
                    3: set_pulses($urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                                  $urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                                  $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
                    default: begin
                        v = 16'($urandom);
                        set_pulses(16'($urandom), v, v);
                    end
                endcase
            end
            nframes++;
            kind = $urandom_range(0, 19);
            for (int k = 0; k < N_WORDS; k++)
                w[k] = ($urandom_range(0, 5) == 0) ? 16'($urandom) : pick_word();
            t1 = TRL_FIRST;
            t2 = TRL_SECOND;
            if (kind <= 16) begin
                if (kind >= 15) begin
                    if ($urandom_range(0, 1)) begin
                        t1 = noise_byte();
                        if (t1 == TRL_FIRST) t1 = 8'h00;
                    end else begin
                        t2 = noise_byte();
                        if (t2 == TRL_SECOND) t2 = 8'hFF;
                    end
                end
                nhdr = $urandom_range(1, 3);
                send_frame(nhdr, w, t1, t2, 1'b0, '0);
                rand_bytes += nhdr + USED_BYTES + 3;
            end else if (kind <= 18) begin
                repeat ($urandom_range(1, 8)) begin
                    send_byte(noise_byte(), 1'b0, '0);
                    rand_bytes++;
                end
            end else begin
                // cut frame short after a partial payload
                send_byte(HDR_FIRST, 1'b0, '0);
                send_byte(HDR_SECOND, 1'b0, '0);
                repeat ($urandom_range(0, USED_BYTES - 1)) begin
                    send_byte(8'($urandom), 1'b0, '0);
                    rand_bytes++;
                end
                rand_bytes += 2;
            end
        end

        s_valid <= 1'b0;
        while (pending_chans.size() != 0) @(posedge aclk);
        repeat (CFG_SETTLE * 4) @(posedge aclk);
        mismatch_cnt += pending_chans.size();
        if (mismatch_cnt == 0)
            $display("rc_frame_receiver_channel_decode: match");
        else
            $display("rc_frame_receiver_channel_decode: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/rcfr_pkg.sv
rtl/core/rcfr_div6.sv
rtl/core/rc_frame_receiver_channel_decode.sv
tb/sv/tb.sv
